// ----- hw/rtl/http_chunk_framer_defines.svh -----
// Assertion macros used by the framer RTL (hcf_ctrl).
// Each expects clk and rst_n in scope.
`ifndef HTTP_CHUNK_FRAMER_DEFINES_SVH
`define HTTP_CHUNK_FRAMER_DEFINES_SVH

// Same-cycle implication.
`define HCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/hcf_pkg.sv -----
package hcf_pkg;

    // Buffer depth default and register widths
    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int CFG_W            = 6;
    localparam int PADDR_W          = 2;
    localparam int PDATA_W          = 32;

    localparam logic [CFG_W-1:0]   MAX_CHUNK_RST  = 6'd32;
    localparam logic [PADDR_W-1:0] ADDR_MAX_CHUNK = 2'd0;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE        = 2'd0,
        KIND_HDR_LEN     = 2'd1,
        KIND_HDR_CHUNKED = 2'd2,
        KIND_FLUSH       = 2'd3
    } kind_t;

    // Input opcodes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // One nibble to lower-case ASCII hex
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = 8'h30 + {4'h0, d};
        end
        else
        begin
            r = 8'h57 + {4'h0, d};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/hcf_ram.sv -----
module hcf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; rdata holds without re
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/hcf_cfg.sv -----
module hcf_cfg
    import hcf_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CNT_W-1:0]   eff_len
);

    logic [CFG_W-1:0] max_chunk_reg;
    logic [CFG_W-1:0] max_chunk_next;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == ADDR_MAX_CHUNK);

    // Register write
    always_comb
    begin
        max_chunk_next = max_chunk_reg;
        if (wr_hit)
        begin
            max_chunk_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chunk_reg <= MAX_CHUNK_RST;
        end
        else
        begin
            max_chunk_reg <= max_chunk_next;
        end
    end

    // Readback
    assign prdata = (paddr == ADDR_MAX_CHUNK) ? PDATA_W'(max_chunk_reg) : '0;

    // Effective chunk length, clamped to 1..BUFFER_DEPTH
    always_comb
    begin
        if (max_chunk_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (max_chunk_reg > CFG_W'(BUFFER_DEPTH))
        begin
            eff_len = CNT_W'(BUFFER_DEPTH);
        end
        else
        begin
            eff_len = CNT_W'(max_chunk_reg);
        end
    end

endmodule

// ----- hw/rtl/hcf_ctrl.sv -----
`include "http_chunk_framer_defines.svh"

module hcf_ctrl
    import hcf_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1),
    parameter int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] eff_len,
    // input words
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             opcode,
    input  logic [7:0]       data_byte,
    // result words
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       out_byte,
    output logic [CFG_W-1:0] content_length,
    output logic             last,
    // buffer memory
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [7:0]       ram_wdata,
    output logic             ram_re,
    output logic [AW-1:0]    ram_raddr,
    input  logic [7:0]       ram_rdata
);

    localparam int NIB_N = (CNT_W + 3) / 4;
    localparam int NIB_W = (NIB_N > 1) ? $clog2(NIB_N) : 1;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_HDR  = 10'b00_0000_0010,
        ST_HEX  = 10'b00_0000_0100,
        ST_CR1  = 10'b00_0000_1000,
        ST_LF1  = 10'b00_0001_0000,
        ST_RD   = 10'b00_0010_0000,
        ST_DATA = 10'b00_0100_0000,
        ST_CR2  = 10'b00_1000_0000,
        ST_LF2  = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } state_t;

    state_t           state_reg,   state_next;
    logic [CNT_W-1:0] fill_reg,    fill_next;
    logic             hdr_sent_reg, hdr_sent_next;
    logic             flush_reg,   flush_next;
    logic             framed_reg,  framed_next;
    logic [CNT_W-1:0] clen_reg,    clen_next;
    logic [NIB_W-1:0] nib_reg,     nib_next;
    logic [AW-1:0]    idx_reg,     idx_next;
    logic [7:0]       byte_reg,    byte_next;

    logic             out_valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       out_byte_reg;
    logic [CFG_W-1:0] len_reg;
    logic             last_reg;

    logic             accept;
    logic             free;
    logic             full;
    logic             idx_last;
    logic [NIB_N*4-1:0] clen_pad;

    logic             push;
    kind_t            push_kind;
    logic [7:0]       push_data;
    logic [CFG_W-1:0] push_len;
    logic             push_last;

    // Index of the highest nonzero nibble, 0 for a zero value
    function automatic logic [NIB_W-1:0] top_nib(input logic [CNT_W-1:0] v);
        logic [NIB_N*4-1:0] p;
        logic [NIB_W-1:0]   r;
        p = (NIB_N*4)'(v);
        r = '0;
        for (int k = 0; k < NIB_N; k++)
        begin
            if (p[k*4 +: 4] != 4'd0)
            begin
                r = NIB_W'(k);
            end
        end
        return r;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign free     = !out_valid_reg || out_ready;
    assign full     = (fill_reg >= eff_len);
    assign idx_last = (CNT_W'(idx_reg) == (clen_reg - CNT_W'(1)));
    assign clen_pad = (NIB_N*4)'(clen_reg);

    // Sequencer: buffer writes, buffer reads and result generation
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        hdr_sent_next = hdr_sent_reg;
        flush_next    = flush_reg;
        framed_next   = framed_reg;
        clen_next     = clen_reg;
        nib_next      = nib_reg;
        idx_next      = idx_reg;
        byte_next     = byte_reg;

        push      = 1'b0;
        push_kind = KIND_BYTE;
        push_data = '0;
        push_len  = '0;
        push_last = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = fill_reg[AW-1:0];
        ram_wdata = data_byte;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    clen_next = fill_reg;
                    nib_next  = top_nib(fill_reg);
                    if (opcode == OP_WRITE)
                    begin
                        if (full)
                        begin
                            // full buffer goes out as a chunk first
                            byte_next   = data_byte;
                            flush_next  = 1'b0;
                            framed_next = 1'b1;
                            state_next  = hdr_sent_reg ? ST_HEX : ST_HDR;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        flush_next  = 1'b1;
                        framed_next = hdr_sent_reg;
                        state_next  = hdr_sent_reg ? ST_HEX : ST_HDR;
                    end
                end
            end
            ST_HDR:
            begin
                if (free)
                begin
                    push = 1'b1;
                    if (framed_reg)
                    begin
                        push_kind     = KIND_HDR_CHUNKED;
                        hdr_sent_next = 1'b1;
                        state_next    = ST_HEX;
                    end
                    else
                    begin
                        push_kind  = KIND_HDR_LEN;
                        push_len   = CFG_W'(clen_reg);
                        idx_next   = '0;
                        state_next = (clen_reg != '0) ? ST_RD : ST_FIN;
                    end
                end
            end
            ST_HEX:
            begin
                if (free)
                begin
                    push      = 1'b1;
                    push_data = hex_char(clen_pad[nib_reg*4 +: 4]);
                    if (nib_reg == '0)
                    begin
                        state_next = ST_CR1;
                    end
                    else
                    begin
                        nib_next = nib_reg - NIB_W'(1);
                    end
                end
            end
            ST_CR1:
            begin
                if (free)
                begin
                    push       = 1'b1;
                    push_data  = CHAR_CR;
                    state_next = ST_LF1;
                end
            end
            ST_LF1:
            begin
                if (free)
                begin
                    push       = 1'b1;
                    push_data  = CHAR_LF;
                    idx_next   = '0;
                    state_next = (clen_reg != '0) ? ST_RD : ST_CR2;
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (free)
                begin
                    push      = 1'b1;
                    push_data = ram_rdata;
                    if (idx_last)
                    begin
                        state_next = framed_reg ? ST_CR2 : ST_FIN;
                    end
                    else
                    begin
                        // fetch the next byte while this one leaves
                        idx_next  = idx_reg + AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + AW'(1);
                    end
                end
            end
            ST_CR2:
            begin
                if (free)
                begin
                    push       = 1'b1;
                    push_data  = CHAR_CR;
                    state_next = ST_LF2;
                end
            end
            ST_LF2:
            begin
                if (free)
                begin
                    push      = 1'b1;
                    push_data = CHAR_LF;
                    if (!flush_reg)
                    begin
                        // held byte opens the next chunk
                        push_last  = 1'b1;
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = byte_reg;
                        fill_next  = CNT_W'(1);
                        state_next = ST_IDLE;
                    end
                    else if (clen_reg != '0)
                    begin
                        // terminator chunk
                        clen_next  = '0;
                        nib_next   = '0;
                        state_next = ST_HEX;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (free)
                begin
                    push          = 1'b1;
                    push_kind     = KIND_FLUSH;
                    push_last     = 1'b1;
                    fill_next     = '0;
                    hdr_sent_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            hdr_sent_reg  <= 1'b0;
            flush_reg     <= 1'b0;
            framed_reg    <= 1'b0;
            clen_reg      <= '0;
            nib_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            hdr_sent_reg <= hdr_sent_next;
            flush_reg    <= flush_next;
            framed_reg   <= framed_next;
            clen_reg     <= clen_next;
            nib_reg      <= nib_next;
            idx_reg      <= idx_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (push)
        begin
            kind_reg     <= push_kind;
            out_byte_reg <= push_data;
            len_reg      <= push_len;
            last_reg     <= push_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign out_byte       = out_byte_reg;
    assign content_length = len_reg;
    assign last           = last_reg;

    `HCF_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CNT_W'(BUFFER_DEPTH), "fill count beyond buffer depth")
    `HCF_ASSERT_NEXT(a_fill_inc, accept && (opcode == OP_WRITE) && !full, fill_reg == $past(fill_reg) + CNT_W'(1), "buffered write lost")
    `HCF_ASSERT_NEXT(a_fin_clear, push && (state_reg == ST_FIN), (fill_reg == '0) && !hdr_sent_reg && in_ready, "stream state not cleared after flush")
    `HCF_ASSERT_NOW(a_push_free, push, free, "word pushed into occupied output register")
    `HCF_ASSERT_NOW(a_ram_port, ram_we, !ram_re, "buffer read and write overlap")

endmodule

// ----- hw/rtl/http_chunk_framer.sv -----
// Channel   Handshake             Payload
// apb       psel/penable/pready   paddr, pwdata -> max_chunk_len, prdata
// in        in_valid/in_ready     opcode, data_byte
// out       out_valid/out_ready   kind, out_byte, content_length, last
//
// A write into a non-full buffer gives no words.
// A chunk goes out as hex digits, CR, LF, data bytes, CR, LF; while out_ready is high
// one word per cycle leaves the output register, paced by the registered RAM read.
// A flush adds headers or the terminator chunk and the destination-flush word.
// Reset is asynchronous, active low; the buffer memory is not cleared.
// A stall on out holds the sequencer; in is taken again once the last word is queued.
module http_chunk_framer
    import hcf_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [7:0]         data_byte,
    // result words
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [7:0]         out_byte,
    output logic [CFG_W-1:0]   content_length,
    output logic               last
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int AW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [CNT_W-1:0] eff_len;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;

    // Configuration register
    hcf_cfg #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .CNT_W        (CNT_W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eff_len (eff_len)
    );

    // Chunk buffer
    hcf_ram #(
        .WIDTH  (8),
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (AW)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Framing sequencer and output register
    hcf_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .CNT_W        (CNT_W),
        .AW           (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .eff_len        (eff_len),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .out_byte       (out_byte),
        .content_length (content_length),
        .last           (last),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

endmodule
